// File: rtl/hsog_pkg.sv
// Package: shared widths, reset values and defaults for the sequency-order generator.
package hsog_pkg;

  localparam int CFG_W        = 4;
  localparam int PATTERN_W    = 10;
  localparam int SEQ_W        = 11;
  localparam int RANK_W       = 20;
  localparam int MAX_LOG2_DEF = 10;

  localparam logic [CFG_W-1:0] LOG2_SIZE_RESET = 4'd6;

endpackage

// File: rtl/hsog_row_unit.sv
// Row test unit: checks one row against the current sequency level and names the pattern.
module hsog_row_unit #(
  parameter int MAX_LOG2 = hsog_pkg::MAX_LOG2_DEF,
  localparam int LW  = MAX_LOG2 + 1,
  localparam int LGW = $clog2(MAX_LOG2 + 1)
) (
  input  logic [LW-1:0]       level,
  input  logic [MAX_LOG2-1:0] row,
  input  logic [LGW-1:0]      lg,
  output logic                hit,
  output logic [MAX_LOG2-1:0] rev_u,
  output logic [MAX_LOG2-1:0] rev_v
);
  import hsog_pkg::*;

  logic [MAX_LOG2-1:0] gray;
  logic [LW-1:0]       diff;
  logic [LW-1:0]       side;
  logic [MAX_LOG2-1:0] vbin;
  logic [MAX_LOG2-1:0] ru;
  logic [MAX_LOG2-1:0] rv;
  logic [LGW-1:0]      sh;

  assign gray = row ^ (row >> 1);
  assign diff = level - LW'(gray);
  assign side = LW'(1) << lg;
  assign hit  = (level >= LW'(gray)) && (diff < side);

  always_comb begin
    for (int i = 0; i < MAX_LOG2; i++) begin
      vbin[i] = ^(diff[MAX_LOG2-1:0] >> i);
      ru[i]   = row[MAX_LOG2-1-i];
    end
    for (int i = 0; i < MAX_LOG2; i++) begin
      rv[i] = vbin[MAX_LOG2-1-i];
    end
  end

  // bit reversal over lg bits: full-width reverse, then drop the unused low end
  assign sh    = LGW'(MAX_LOG2) - lg;
  assign rev_u = ru >> sh;
  assign rev_v = rv >> sh;

endmodule

// File: rtl/hadamard_sequency_order_generator.sv
// Top level: 2D Hadamard pattern generator in rising sequency order.
//
//   port group  | direction | handshake           | payload
//   cfg_        | in        | cfg_wr_en           | cfg_wr_data (log2_size)
//   in_         | in        | in_valid / in_stall | in_restart
//   out_        | out       | out_valid/out_stall | pattern_u, pattern_v, sequency, rank, last
//
// After an accept, the search state tests one row or advances one level at a time
// in the row test unit until a hit is found; no new request is taken meanwhile.
// in_stall is high from accept until the result is loaded into the output register.
// A found result waits in the search state while the output register is stalled.
// rst_n is synchronous; reset sets log2_size to 6 and restarts the sequence.
module hadamard_sequency_order_generator #(
  parameter int MAX_LOG2 = hsog_pkg::MAX_LOG2_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hsog_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hsog_pkg::PATTERN_W-1:0] out_pattern_u,
  output logic [hsog_pkg::PATTERN_W-1:0] out_pattern_v,
  output logic [hsog_pkg::SEQ_W-1:0]     out_sequency,
  output logic [hsog_pkg::RANK_W-1:0]    out_rank,
  output logic                           out_last
);
  import hsog_pkg::*;

  localparam int LW  = MAX_LOG2 + 1;
  localparam int CW  = 2 * MAX_LOG2 + 1;
  localparam int LGW = $clog2(MAX_LOG2 + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [LW-1:0]    level_r, level_nxt;
  logic [LW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    emitted_r, emitted_nxt;

  logic                 out_valid_r;
  logic [PATTERN_W-1:0] out_pattern_u_r;
  logic [PATTERN_W-1:0] out_pattern_v_r;
  logic [SEQ_W-1:0]     out_sequency_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic                 out_last_r;

  logic [LGW-1:0]      lg;
  logic [LW-1:0]       side;
  logic [LW-1:0]       top;
  logic [CW-1:0]       total;
  logic [CW-1:0]       emitted_inc;
  logic                in_accept;
  logic                out_free;
  logic                hit;
  logic                load;
  logic                last;
  logic [MAX_LOG2-1:0] rev_u;
  logic [MAX_LOG2-1:0] rev_v;

  always_comb begin
    if (32'(cfg_r) > MAX_LOG2) begin
      lg = LGW'(MAX_LOG2);
    end else begin
      lg = LGW'(cfg_r);
    end
  end

  assign side        = LW'(1) << lg;
  assign top         = (side - LW'(1)) << 1;
  assign total       = CW'(1) << {lg, 1'b0};
  assign emitted_inc = emitted_r + CW'(1);
  assign last        = emitted_inc >= total;
  assign in_accept   = in_valid && (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;

  hsog_row_unit #(
    .MAX_LOG2(MAX_LOG2)
  ) u_row_unit (
    .level (level_r),
    .row   (row_r[MAX_LOG2-1:0]),
    .lg    (lg),
    .hit   (hit),
    .rev_u (rev_u),
    .rev_v (rev_v)
  );

  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    row_nxt     = row_r;
    emitted_nxt = emitted_r;
    load        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SEARCH;
          if (in_restart || (emitted_r >= total)) begin
            level_nxt   = '0;
            row_nxt     = '0;
            emitted_nxt = '0;
          end
        end
      end
      ST_SEARCH: begin
        if (level_r > top) begin
          level_nxt   = '0;
          row_nxt     = '0;
          emitted_nxt = '0;
        end else if (row_r >= side) begin
          level_nxt = level_r + LW'(1);
          row_nxt   = '0;
        end else if (hit) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
            if (last) begin
              level_nxt   = '0;
              row_nxt     = '0;
              emitted_nxt = '0;
            end else begin
              row_nxt     = row_r + LW'(1);
              emitted_nxt = emitted_inc;
            end
          end
        end else begin
          row_nxt = row_r + LW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // register write restarts the sequence
    if (cfg_wr_en) begin
      level_nxt   = '0;
      row_nxt     = '0;
      emitted_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= LOG2_SIZE_RESET;
      level_r     <= '0;
      row_r       <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      level_r   <= level_nxt;
      row_r     <= row_nxt;
      emitted_r <= emitted_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pattern_u_r <= PATTERN_W'(rev_u);
      out_pattern_v_r <= PATTERN_W'(rev_v);
      out_sequency_r  <= SEQ_W'(level_r);
      out_rank_r      <= RANK_W'(emitted_r);
      out_last_r      <= last;
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pattern_u = out_pattern_u_r;
  assign out_pattern_v = out_pattern_v_r;
  assign out_sequency  = out_sequency_r;
  assign out_rank      = out_rank_r;
  assign out_last      = out_last_r;

endmodule

// File: rtl/hsog_checker.sv
// Port checker for the sequency-order generator, bound to the top level.
module hsog_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hsog_pkg::PATTERN_W-1:0] out_pattern_u,
  input logic [hsog_pkg::PATTERN_W-1:0] out_pattern_v,
  input logic [hsog_pkg::SEQ_W-1:0]     out_sequency,
  input logic [hsog_pkg::RANK_W-1:0]    out_rank,
  input logic                           out_last
);
  import hsog_pkg::*;

  // busy after every accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("in_stall low right after an accepted word");

  // ready again only together with a fresh result
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(in_stall) && $past(rst_n)) |-> out_valid)
    else $error("in_stall fell without a result word");

  // first pattern of any sequence is the all-zero one
  a_first_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rank == '0)) |->
      ((out_sequency == '0) && (out_pattern_u == '0) && (out_pattern_v == '0)))
    else $error("rank 0 word is not the zero pattern");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pattern_u) && $stable(out_pattern_v)
       && $stable(out_sequency) && $stable(out_rank) && $stable(out_last)))
    else $error("stalled result word changed");

endmodule

bind hadamard_sequency_order_generator hsog_checker u_hsog_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pattern_u (out_pattern_u),
  .out_pattern_v (out_pattern_v),
  .out_sequency  (out_sequency),
  .out_rank      (out_rank),
  .out_last      (out_last)
);

// File: tb/tb_hadamard_sequency_order_generator.sv
// Testbench: checks sequency-ordered Hadamard pattern words against an in-bench predictor.
module tb_hadamard_sequency_order_generator;
  import hsog_pkg::*;

  localparam int MAX_LOG2   = MAX_LOG2_DEF;
  localparam int RAND_ITEMS = 1350;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 2100;

  typedef struct packed {
    logic [PATTERN_W-1:0] u;
    logic [PATTERN_W-1:0] v;
    logic [SEQ_W-1:0]     seq;
    logic [RANK_W-1:0]    rank;
    logic                 last;
  } pattern_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PATTERN_W-1:0] out_pattern_u;
  logic [PATTERN_W-1:0] out_pattern_v;
  logic [SEQ_W-1:0]     out_sequency;
  logic [RANK_W-1:0]    out_rank;
  logic                 out_last;

  // predictor state
  logic [CFG_W-1:0] size_lg = LOG2_SIZE_RESET;
  logic [31:0]      seq_level = '0;
  logic [31:0]      seq_row = '0;
  logic [63:0]      seq_count = '0;

  logic        restart_q[$];
  pattern_t    pattern_q[$];
  int          restart_idx = 0;
  int          pattern_idx = 0;
  int          errors = 0;
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 67;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  hadamard_sequency_order_generator #(
    .MAX_LOG2(MAX_LOG2)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pattern_u(out_pattern_u),
    .out_pattern_v(out_pattern_v),
    .out_sequency(out_sequency),
    .out_rank(out_rank),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  task automatic clear_sequence();
    seq_level = '0;
    seq_row   = '0;
    seq_count = '0;
  endtask

  task automatic next_pattern(input logic restart, output pattern_t p);
    logic [31:0] lg, side, top, g, v, ur, vr;
    logic [63:0] total;
    bit          found;
    lg    = (size_lg > MAX_LOG2) ? MAX_LOG2 : size_lg;
    side  = 32'd1 << lg;
    total = 64'(side) * 64'(side);
    top   = 2 * (side - 1);
    v     = '0;
    found = 1'b0;
    if (restart || seq_count >= total) clear_sequence();
    while (!found) begin
      if (seq_level > top) clear_sequence();
      if (seq_row >= side) begin
        seq_level++;
        seq_row = '0;
      end else begin
        g = seq_row ^ (seq_row >> 1);
        if (seq_level >= g && seq_level - g < side) begin
          v = seq_level - g;
          for (int s = 1; s < 32; s <<= 1) v ^= v >> s;
          found = 1'b1;
        end else begin
          seq_row++;
        end
      end
    end
    ur = '0;
    vr = '0;
    for (int b = 0; b < lg; b++) begin
      ur = (ur << 1) | seq_row[b];
      vr = (vr << 1) | v[b];
    end
    p.u    = ur[PATTERN_W-1:0];
    p.v    = vr[PATTERN_W-1:0];
    p.seq  = seq_level[SEQ_W-1:0];
    p.rank = seq_count[RANK_W-1:0];
    seq_count++;
    seq_row++;
    p.last = (seq_count >= total);
    if (p.last) clear_sequence();
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin : drv
    pattern_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_lg = cfg_wr_data;
        clear_sequence();
      end
      if (in_valid && !in_stall) begin
        next_pattern(in_restart, p);
        pattern_q.push_back(p);
      end
      if (!in_valid || !in_stall) begin
        if (restart_idx < restart_q.size() && $urandom_range(99) >= tx_idle_pct) begin
          in_valid    <= 1'b1;
          in_restart  <= restart_q[restart_idx];
          restart_idx <= restart_idx + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_left <= HOLD_LEN;
      hold_ack  <= hold_req;
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    pattern_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pattern_idx >= pattern_q.size()) begin
          report_mismatch($sformatf("word u=%0d v=%0d rank=%0d with none expected",
                                    out_pattern_u, out_pattern_v, out_rank));
        end else begin
          want = pattern_q[pattern_idx];
          if (out_pattern_u !== want.u || out_pattern_v !== want.v ||
              out_sequency !== want.seq || out_rank !== want.rank ||
              out_last !== want.last)
            report_mismatch($sformatf(
              "got u=%0d v=%0d seq=%0d rank=%0d last=%0b, want u=%0d v=%0d seq=%0d rank=%0d last=%0b",
              out_pattern_u, out_pattern_v, out_sequency, out_rank, out_last,
              want.u, want.v, want.seq, want.rank, want.last));
          pattern_idx <= pattern_idx + 1;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (restart_idx < restart_q.size() || in_valid || pattern_idx < pattern_q.size());
  endtask

  task automatic write_size(input logic [CFG_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned lg, n, done, k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, then size one, wrap, clamped size, largest size, rewrite restart
    restart_q.push_back(1'b1);
    repeat (3) restart_q.push_back(1'b0);
    write_size(4'd0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    write_size(4'd1);
    repeat (5) restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    write_size(4'd15);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    write_size(4'd10);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    write_size(4'd2);
    repeat (3) restart_q.push_back(1'b0);
    write_size(4'd2);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);

    done = 0;
    k = 0;
    while (done < RAND_ITEMS) begin
      if (done < RAND_ITEMS / 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 67;
      end else if (done < 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 67;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      lg = (k % 6 == 5) ? $urandom_range(15, 8) : $urandom_range(7, 0);
      n  = (lg >= 8) ? $urandom_range(15, 5) : $urandom_range(120, 40);
      write_size(lg[CFG_W-1:0]);
      for (int i = 0; i < n; i++) begin
        if (k == 1 && i == n / 2) drain();
        restart_q.push_back($urandom_range(15) == 0);
      end
      if (k == 0) hold_req++;
      done += n;
      k++;
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
